FILE: rtl/qpcs_pkg.sv
package qpcs_pkg;

    // Store and counter sizes
    localparam int PENDING_DEPTH = 8;
    localparam int MAX_NEST      = 255;
    localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);
    localparam int PTR_W         = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int NEST_W        = $clog2(MAX_NEST + 1);
    localparam int IDX_W         = 16;
    localparam logic [IDX_W-1:0] COUNT_MAX = {IDX_W{1'b1}};

    // Characters with a role in the split
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // What one incoming byte means in the current scan state
    typedef struct packed {
        logic is_end;
        logic split;
        logic is_ws;
        logic quote_exit;
        logic quote_enter;
        logic quote_dbl;
        logic paren_open;
        logic paren_close;
    } char_class_t;

endpackage

FILE: rtl/qpcs_classify.sv
module qpcs_classify
    import qpcs_pkg::*;
(
    input  logic [7:0]  char_code,
    input  logic        end_of_string,
    input  logic        in_quote,
    input  logic        quote_is_double,
    input  logic        paren_zero,
    output char_class_t cls
);

    logic [7:0] close_quote;

    assign close_quote = quote_is_double ? CH_DQUOTE : CH_SQUOTE;

    // Decode the byte against quote and nesting state
    always_comb
    begin
        cls.is_end      = end_of_string || (char_code == CH_NUL);
        cls.is_ws       = (char_code == CH_SPACE) || (char_code inside {[CH_TAB:CH_CR]});
        cls.quote_exit  = 1'b0;
        cls.quote_enter = 1'b0;
        cls.quote_dbl   = 1'b0;
        cls.paren_open  = 1'b0;
        cls.paren_close = 1'b0;
        cls.split       = 1'b0;
        if (!cls.is_end)
        begin
            if (in_quote)
            begin
                cls.quote_exit = (char_code == close_quote);
            end
            else
            begin
                cls.split       = (char_code == CH_COMMA) && paren_zero;
                cls.quote_enter = (char_code == CH_SQUOTE) || (char_code == CH_DQUOTE);
                cls.quote_dbl   = (char_code == CH_DQUOTE);
                cls.paren_open  = (char_code == CH_OPEN);
                cls.paren_close = (char_code == CH_CLOSE);
            end
        end
    end

endmodule

FILE: rtl/quote_paren_aware_comma_splitter.sv
// Splits a byte stream on commas outside quotes and parentheses, trims
// whitespace from each token and drops empty tokens. One byte enters per
// cycle unless stalled; each result leaves through a single output
// register. A byte that releases held whitespace gives n+1 results, where
// n is the number of held whitespace bytes (at most PENDING_DEPTH): the
// held bytes, then the byte itself, one per cycle while the output is not
// stalled. An end item with an open token gives an end-of-token mark, then
// string done. The item channel stalls while those extra results drain
// and whenever the output register is full and stalled.
module quote_paren_aware_comma_splitter
    import qpcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic [7:0]       char_code,
    input  logic             end_of_string,
    output logic             result_valid,
    input  logic             result_stall,
    output logic [1:0]       kind,
    output logic [7:0]       char_out,
    output logic [IDX_W-1:0] token_index,
    output logic [IDX_W-1:0] token_total,
    output logic             overflow,
    output logic             last
);

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_TOKEN_END = 2'd1,
        KIND_DONE      = 2'd2
    } kind_t;

    // Scan state
    logic              in_quote_reg, in_quote_next;
    logic              qdbl_reg, qdbl_next;
    logic [NEST_W-1:0] depth_reg, depth_next;
    logic              started_reg, started_next;
    logic [CNT_W-1:0]  pcount_reg, pcount_next;
    logic [IDX_W-1:0]  tc_reg, tc_next;
    logic              ovf_reg, ovf_next;
    logic [7:0]        pend_reg [PENDING_DEPTH];

    // Drain sequencer
    logic              seq_active_reg, seq_active_next;
    logic [CNT_W-1:0]  seq_pos_reg, seq_pos_next;
    logic [CNT_W-1:0]  seq_cnt_reg, seq_cnt_next;
    logic [IDX_W-1:0]  seq_idx_reg, seq_idx_next;
    kind_t             seq_kind_reg, seq_kind_next;
    logic [7:0]        seq_char_reg, seq_char_next;
    logic [IDX_W-1:0]  seq_total_reg, seq_total_next;
    logic              seq_ovf_reg, seq_ovf_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    kind_t             out_kind_reg, out_kind_next;
    logic [7:0]        out_char_reg, out_char_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic [IDX_W-1:0]  out_total_reg, out_total_next;
    logic              out_ovf_reg, out_ovf_next;
    logic              out_last_reg, out_last_next;

    char_class_t       cls;
    logic              out_load;
    logic              acc;
    logic [IDX_W-1:0]  tc_inc;
    logic              pend_wr;

    qpcs_classify u_classify (
        .char_code       (char_code),
        .end_of_string   (end_of_string),
        .in_quote        (in_quote_reg),
        .quote_is_double (qdbl_reg),
        .paren_zero      (depth_reg == '0),
        .cls             (cls)
    );

    // Handshake: the output register frees when empty or taken
    assign out_load   = !out_valid_reg || !result_stall;
    assign item_stall = seq_active_reg || !out_load;
    assign acc        = item_valid && !item_stall;
    assign tc_inc     = (started_reg && (tc_reg != COUNT_MAX)) ? tc_reg + 1'b1 : tc_reg;

    assign result_valid = out_valid_reg;
    assign kind         = out_kind_reg;
    assign char_out     = out_char_reg;
    assign token_index  = out_idx_reg;
    assign token_total  = out_total_reg;
    assign overflow     = out_ovf_reg;
    assign last         = out_last_reg;

    always_comb
    begin
        in_quote_next   = in_quote_reg;
        qdbl_next       = qdbl_reg;
        depth_next      = depth_reg;
        started_next    = started_reg;
        pcount_next     = pcount_reg;
        tc_next         = tc_reg;
        ovf_next        = ovf_reg;
        pend_wr         = 1'b0;
        seq_active_next = seq_active_reg;
        seq_pos_next    = seq_pos_reg;
        seq_cnt_next    = seq_cnt_reg;
        seq_idx_next    = seq_idx_reg;
        seq_kind_next   = seq_kind_reg;
        seq_char_next   = seq_char_reg;
        seq_total_next  = seq_total_reg;
        seq_ovf_next    = seq_ovf_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_char_next   = out_char_reg;
        out_idx_next    = out_idx_reg;
        out_total_next  = out_total_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;

        // Drop the result once taken
        if (out_load)
        begin
            out_valid_next = 1'b0;
        end

        // Advance the drain: held bytes first, then the closing result
        if (seq_active_reg && out_load)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = seq_idx_reg;
            out_total_next = '0;
            out_ovf_next   = 1'b0;
            if (seq_pos_reg < seq_cnt_reg)
            begin
                out_kind_next = KIND_BYTE;
                out_char_next = pend_reg[seq_pos_reg[PTR_W-1:0]];
                out_last_next = 1'b0;
                seq_pos_next  = seq_pos_reg + 1'b1;
            end
            else
            begin
                out_kind_next   = seq_kind_reg;
                out_char_next   = seq_char_reg;
                out_total_next  = seq_total_reg;
                out_ovf_next    = seq_ovf_reg;
                out_last_next   = 1'b1;
                seq_active_next = 1'b0;
            end
        end

        // Take a new item
        if (acc)
        begin
            if (cls.is_end)
            begin
                // Close any open token, report, and return to reset state
                out_valid_next = 1'b1;
                out_char_next  = 8'h00;
                if (started_reg)
                begin
                    out_kind_next   = KIND_TOKEN_END;
                    out_idx_next    = tc_reg;
                    out_total_next  = '0;
                    out_ovf_next    = 1'b0;
                    out_last_next   = 1'b0;
                    seq_active_next = 1'b1;
                    seq_pos_next    = '0;
                    seq_cnt_next    = '0;
                    seq_idx_next    = '0;
                    seq_kind_next   = KIND_DONE;
                    seq_char_next   = 8'h00;
                    seq_total_next  = tc_inc;
                    seq_ovf_next    = ovf_reg;
                end
                else
                begin
                    out_kind_next  = KIND_DONE;
                    out_idx_next   = '0;
                    out_total_next = tc_reg;
                    out_ovf_next   = ovf_reg;
                    out_last_next  = 1'b1;
                end
                in_quote_next = 1'b0;
                qdbl_next     = 1'b0;
                depth_next    = '0;
                started_next  = 1'b0;
                pcount_next   = '0;
                tc_next       = '0;
                ovf_next      = 1'b0;
            end
            else if (cls.split)
            begin
                // Split comma: mark the token end, drop held whitespace
                if (started_reg)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_TOKEN_END;
                    out_char_next  = 8'h00;
                    out_idx_next   = tc_reg;
                    out_total_next = '0;
                    out_ovf_next   = 1'b0;
                    out_last_next  = 1'b1;
                end
                tc_next      = tc_inc;
                started_next = 1'b0;
                pcount_next  = '0;
            end
            else
            begin
                // Track quotes and nesting
                if (cls.quote_exit)
                begin
                    in_quote_next = 1'b0;
                    qdbl_next     = 1'b0;
                end
                if (cls.quote_enter)
                begin
                    in_quote_next = 1'b1;
                    qdbl_next     = cls.quote_dbl;
                end
                if (cls.paren_open && (depth_reg != NEST_W'(MAX_NEST)))
                begin
                    depth_next = depth_reg + 1'b1;
                end
                if (cls.paren_close && (depth_reg != '0))
                begin
                    depth_next = depth_reg - 1'b1;
                end

                if (cls.is_ws)
                begin
                    // Hold whitespace inside a token, flag when full
                    if (started_reg)
                    begin
                        if (pcount_reg < CNT_W'(PENDING_DEPTH))
                        begin
                            pend_wr     = 1'b1;
                            pcount_next = pcount_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    // Release held whitespace, then the byte itself
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_BYTE;
                    out_idx_next   = tc_reg;
                    out_total_next = '0;
                    out_ovf_next   = 1'b0;
                    if (pcount_reg != '0)
                    begin
                        out_char_next   = pend_reg[0];
                        out_last_next   = 1'b0;
                        seq_active_next = 1'b1;
                        seq_pos_next    = CNT_W'(1);
                        seq_cnt_next    = pcount_reg;
                        seq_idx_next    = tc_reg;
                        seq_kind_next   = KIND_BYTE;
                        seq_char_next   = char_code;
                        seq_total_next  = '0;
                        seq_ovf_next    = 1'b0;
                    end
                    else
                    begin
                        out_char_next = char_code;
                        out_last_next = 1'b1;
                    end
                    pcount_next  = '0;
                    started_next = 1'b1;
                end
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_quote_reg   <= 1'b0;
            qdbl_reg       <= 1'b0;
            depth_reg      <= '0;
            started_reg    <= 1'b0;
            pcount_reg     <= '0;
            tc_reg         <= '0;
            ovf_reg        <= 1'b0;
            seq_active_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            in_quote_reg   <= in_quote_next;
            qdbl_reg       <= qdbl_next;
            depth_reg      <= depth_next;
            started_reg    <= started_next;
            pcount_reg     <= pcount_next;
            tc_reg         <= tc_next;
            ovf_reg        <= ovf_next;
            seq_active_reg <= seq_active_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (pend_wr)
        begin
            pend_reg[pcount_reg[PTR_W-1:0]] <= char_code;
        end
        seq_pos_reg   <= seq_pos_next;
        seq_cnt_reg   <= seq_cnt_next;
        seq_idx_reg   <= seq_idx_next;
        seq_kind_reg  <= seq_kind_next;
        seq_char_reg  <= seq_char_next;
        seq_total_reg <= seq_total_next;
        seq_ovf_reg   <= seq_ovf_next;
        out_kind_reg  <= out_kind_next;
        out_char_reg  <= out_char_next;
        out_idx_reg   <= out_idx_next;
        out_total_reg <= out_total_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

    // The drain never reads past the held bytes
    a_seq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seq_active_reg |-> (seq_pos_reg <= seq_cnt_reg))
        else $error("drain position beyond held count");

    // Held count never exceeds the store
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pcount_reg <= CNT_W'(PENDING_DEPTH))
        else $error("held whitespace count beyond store depth");

    // String done is always the last result of its item
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == KIND_DONE)) |-> out_last_reg)
        else $error("string done result not marked last");

    // End of string returns the scan state to rest
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && cls.is_end) |=> ((depth_reg == '0) && (pcount_reg == '0)
                                 && !in_quote_reg && !started_reg))
        else $error("scan state not cleared after end of string");

    // Marks carry no byte
    a_mark_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg != KIND_BYTE)) |-> (out_char_reg == 8'h00))
        else $error("non-byte result carries a byte");

endmodule

FILE: sim/testbench.sv
module testbench;

    import qpcs_pkg::*;

    // Result kinds on the output channel
    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_TOKEN_END = 2'd1;
    localparam logic [1:0] KIND_DONE      = 2'd2;

    // Whitespace bytes that the package does not name
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    localparam int PHASE_ITEMS = 125;
    localparam int DRAIN_CYCLES = 2 * PENDING_DEPTH + 8;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       ch;
        logic [IDX_W-1:0] index;
        logic [IDX_W-1:0] total;
        logic             ovf;
        logic             last;
    } split_result_t;

    // Tracks the split state of the string and the results still owed
    class split_scoreboard;
        int               errors = 0;
        split_result_t    expected_results[$];
        split_result_t    staged[$];
        logic [7:0]       held[$];
        bit               quoted = 1'b0;
        bit               quote_double = 1'b0;
        int               depth = 0;
        bit               in_token = 1'b0;
        logic [IDX_W-1:0] token_count = '0;
        bit               overflow_seen = 1'b0;

        function int pending();
            return expected_results.size();
        endfunction

        function bit is_space(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function void add_result(logic [1:0] kind, logic [7:0] ch, logic [IDX_W-1:0] index,
                                 logic [IDX_W-1:0] total, logic ovf);
            split_result_t r;
            r.kind  = kind;
            r.ch    = ch;
            r.index = index;
            r.total = total;
            r.ovf   = ovf;
            r.last  = 1'b0;
            staged.push_back(r);
        endfunction

        // Emit the end mark of an open token and drop held whitespace
        function void close_token();
            if (in_token)
            begin
                add_result(KIND_TOKEN_END, 8'h00, token_count, '0, 1'b0);
                if (token_count != COUNT_MAX)
                    token_count++;
            end
            in_token = 1'b0;
            held.delete();
        endfunction

        function void clear_state();
            quoted        = 1'b0;
            quote_double  = 1'b0;
            depth         = 0;
            in_token      = 1'b0;
            held.delete();
            token_count   = '0;
            overflow_seen = 1'b0;
        endfunction

        // Work out the results that one accepted item causes
        function void note_item(logic [7:0] c, logic eos);
            bit            keep;
            split_result_t r;
            keep = 1'b0;
            if (eos || c == CH_NUL)
            begin
                close_token();
                add_result(KIND_DONE, 8'h00, '0, token_count, overflow_seen);
                clear_state();
            end
            else if (quoted)
            begin
                if (c == (quote_double ? CH_DQUOTE : CH_SQUOTE))
                begin
                    quoted       = 1'b0;
                    quote_double = 1'b0;
                end
                keep = 1'b1;
            end
            else if (c == CH_COMMA && depth == 0)
                close_token();
            else
            begin
                if (c == CH_SQUOTE || c == CH_DQUOTE)
                begin
                    quoted       = 1'b1;
                    quote_double = (c == CH_DQUOTE);
                end
                else if (c == CH_OPEN)
                begin
                    if (depth < MAX_NEST)
                        depth++;
                end
                else if (c == CH_CLOSE)
                begin
                    if (depth > 0)
                        depth--;
                end
                keep = 1'b1;
            end

            // Hold whitespace inside a token, release it ahead of the next byte
            if (keep)
            begin
                if (is_space(c))
                begin
                    if (in_token)
                    begin
                        if (held.size() < PENDING_DEPTH)
                            held.push_back(c);
                        else
                            overflow_seen = 1'b1;
                    end
                end
                else
                begin
                    foreach (held[i])
                        add_result(KIND_BYTE, held[i], token_count, '0, 1'b0);
                    held.delete();
                    add_result(KIND_BYTE, c, token_count, '0, 1'b0);
                    in_token = 1'b1;
                end
            end

            // Mark the final result of this item and queue them all
            if (staged.size() > 0)
            begin
                r = staged.pop_back();
                r.last = 1'b1;
                staged.push_back(r);
            end
            foreach (staged[i])
                expected_results.push_back(staged[i]);
            staged.delete();
        endfunction

        task report(string what);
            $display("%0t mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(split_result_t got);
            split_result_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d char %h", got.kind, got.ch));
                return;
            end
            want = expected_results.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.ch !== want.ch)
                report($sformatf("char_out %h, expected %h", got.ch, want.ch));
            if (got.index !== want.index)
                report($sformatf("token_index %0d, expected %0d", got.index, want.index));
            if (got.total !== want.total)
                report($sformatf("token_total %0d, expected %0d", got.total, want.total));
            if (got.ovf !== want.ovf)
                report($sformatf("overflow %b, expected %b", got.ovf, want.ovf));
            if (got.last !== want.last)
                report($sformatf("last %b, expected %b", got.last, want.last));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    logic [7:0]       char_code = 8'h00;
    logic             end_of_string = 1'b0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    logic [1:0]       kind;
    logic [7:0]       char_out;
    logic [IDX_W-1:0] token_index;
    logic [IDX_W-1:0] token_total;
    logic             overflow;
    logic             last;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int sent_items = 0;

    split_scoreboard book = new();

    quote_paren_aware_comma_splitter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .char_code     (char_code),
        .end_of_string (end_of_string),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .kind          (kind),
        .char_out      (char_out),
        .token_index   (token_index),
        .token_total   (token_total),
        .overflow      (overflow),
        .last          (last)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    // Stall the result channel at random
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < recv_idle_pct);

    // Check every accepted result
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            book.check_result({kind, char_out, token_index, token_total, overflow, last});
    end

    // Offer one item, idling first at random, and hold it until accepted
    task automatic send_item(logic [7:0] c, logic eos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid    <= 1'b1;
        char_code     <= c;
        end_of_string <= eos;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        book.note_item(c, eos);
        sent_items++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_space();
        int roll;
        roll = $urandom_range(0, 5);
        return (roll == 5) ? CH_SPACE : 8'(CH_TAB + roll);
    endfunction

    // Bytes weighted toward the ones that steer the split
    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return 8'($urandom_range(8'h61, 8'h7A));
        else if (roll < 50)
            return CH_COMMA;
        else if (roll < 65)
            return pick_space();
        else if (roll < 70)
            return CH_SQUOTE;
        else if (roll < 75)
            return CH_DQUOTE;
        else if (roll < 81)
            return CH_OPEN;
        else if (roll < 87)
            return CH_CLOSE;
        else
            return 8'($urandom_range(1, 255));
    endfunction

    // One string: mostly shaped content, sometimes pure noise
    task automatic send_random_string();
        int len;
        bit noise;
        len = $urandom_range(0, 18);
        noise = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++)
        begin
            if (noise)
                send_item(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            else if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(6, 11)) send_item(pick_space(), 1'b0);
            else
                send_item(pick_byte(), 1'b0);
        end
        if ($urandom_range(0, 3) == 0)
            send_item(CH_NUL, 1'b0);
        else
            send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic run_phase(int send_pct, int recv_pct);
        int start;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = sent_items;
        while (sent_items - start < PHASE_ITEMS)
            send_random_string();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: trim, full store release, store overflow
        send_idle_pct = 9;
        recv_idle_pct = 52;
        send_text(" a");
        send_item(CH_TAB, 1'b0);
        send_item(CH_LF, 1'b0);
        send_item(CH_VT, 1'b0);
        send_item(CH_FF, 1'b0);
        send_item(CH_CR, 1'b0);
        send_text("    b");
        // Stray close paren, comma inside parens, doubled quote, split
        send_text(")(,)',''',");
        send_item(CH_DQUOTE, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CH_DQUOTE, 1'b0);
        send_item(CH_DQUOTE, 1'b0);
        send_text(", ");
        send_item(8'hFF, 1'b1);
        // Empty tokens only, closed by a zero byte
        send_text(",,");
        send_item(CH_NUL, 1'b0);

        // Random strings under three idling patterns
        run_phase(9, 52);
        run_phase(52, 9);
        run_phase(0, 0);
        item_valid <= 1'b0;

        // Drain what is still owed, then give the block time for strays
        while (book.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop for a hung handshake
    initial
    begin
        #50000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/qpcs_pkg.sv
rtl/qpcs_classify.sv
rtl/quote_paren_aware_comma_splitter.sv
sim/testbench.sv
